@@ hw/rtl/lr_pkg.sv @@
// Package for the line rasterizer: payload structs, line descriptor and
// fixed widths shared by the front, the descriptor queue and the stepper.
// No dependencies.
package lr_pkg;

  // Width of every coordinate field on the ports
  localparam int COORD_W = 6;
  // Depth of the descriptor queue between front and stepper
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } lr_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic               last_pixel;
  } lr_out_t;

  // One classified line, ready for the stepper
  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] major;
    logic [COORD_W-1:0] minor;
    logic               neg_x;
    logic               neg_y;
    logic               x_major;
  } lr_desc_t;

endpackage

@@ hw/rtl/lr_front.sv @@
// Front of the line rasterizer: masks endpoints to the tile, classifies
// the line (direction, major axis, deltas) and enqueues a descriptor.
// Depends on lr_pkg.
module lr_front #(
  parameter int COORD_BITS = 6
) (
  input  lr_pkg::lr_in_t   in_data,
  input  logic             push,
  input  logic             q_full,
  output logic             enq,
  output lr_pkg::lr_desc_t desc
);

  localparam int CW = lr_pkg::COORD_W;

  logic [COORD_BITS-1:0] sx, sy, ex, ey, ax, ay, major, minor;
  logic                  neg_x, neg_y, x_major;

  always_comb begin
    sx      = in_data.start_x[COORD_BITS-1:0];
    sy      = in_data.start_y[COORD_BITS-1:0];
    ex      = in_data.end_x[COORD_BITS-1:0];
    ey      = in_data.end_y[COORD_BITS-1:0];
    neg_x   = ex < sx;
    neg_y   = ey < sy;
    ax      = neg_x ? sx - ex : ex - sx;
    ay      = neg_y ? sy - ey : ey - sy;
    x_major = ax > ay;
    major   = x_major ? ax : ay;
    minor   = x_major ? ay : ax;

    desc.start_x = CW'(sx);
    desc.start_y = CW'(sy);
    desc.major   = CW'(major);
    desc.minor   = CW'(minor);
    desc.neg_x   = neg_x;
    desc.neg_y   = neg_y;
    desc.x_major = x_major;

    // drop zero-length lines here: they produce no pixels
    enq = push && !q_full && (major != '0);
  end

endmodule

@@ hw/rtl/lr_queue.sv @@
// Short descriptor queue between the front and the stepper.
// Depends on lr_pkg.
module lr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             enq,
  input  lr_pkg::lr_desc_t enq_data,
  input  logic             deq,
  output lr_pkg::lr_desc_t head,
  output logic             q_full,
  output logic             q_empty
);

  localparam int DEPTH = lr_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  lr_pkg::lr_desc_t mem [DEPTH];
  lr_pkg::lr_desc_t head_r;
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    return r;
  endfunction

  always_comb begin
    wr_ptr_nxt = enq ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = deq ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (enq && !deq) begin
      count_nxt = count_r + CNTW'(1);
    end else if (deq && !enq) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      mem[wr_ptr_r] <= enq_data;
    end
  end

  // read the entry that will be at the head next cycle; forward a write to it
  always_ff @(posedge clk) begin
    if (enq && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= enq_data;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

  assign head    = head_r;
  assign q_full  = (count_r == CNTW'(DEPTH));
  assign q_empty = (count_r == '0);

endmodule

@@ hw/rtl/lr_stepper.sv @@
// Back of the line rasterizer: steps one line descriptor along its major
// axis with an error accumulator and drives the result register.
// Depends on lr_pkg.
module lr_stepper #(
  parameter int COORD_BITS = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lr_pkg::lr_desc_t head,
  input  logic             q_empty,
  output logic             deq,
  input  logic             pop,
  output logic             empty,
  output lr_pkg::lr_out_t  out_data
);

  localparam int CB = COORD_BITS;
  localparam int CW = lr_pkg::COORD_W;

  lr_pkg::lr_desc_t desc_r, desc_nxt;
  logic             busy_r, busy_nxt;
  logic [CB-1:0]    k_r, k_nxt, m_r, m_nxt;
  logic [CB:0]      acc_r, acc_nxt;
  logic             out_valid_r, out_valid_nxt;
  lr_pkg::lr_out_t  out_data_r, out_data_nxt;

  logic [CB-1:0] sx, sy, major, minor, m_use, ox, oy, px, py;
  logic [CB:0]   maj_w, acc_sub, acc_step;
  logic          wrap, last, step;

  always_comb begin
    sx       = desc_r.start_x[CB-1:0];
    sy       = desc_r.start_y[CB-1:0];
    major    = desc_r.major[CB-1:0];
    minor    = desc_r.minor[CB-1:0];
    maj_w    = {1'b0, major};
    wrap     = acc_r >= maj_w;
    acc_sub  = wrap ? acc_r - maj_w : acc_r;
    acc_step = acc_sub + {1'b0, minor};
    m_use    = m_r + CB'(wrap);
    ox       = desc_r.x_major ? k_r : m_use;
    oy       = desc_r.x_major ? m_use : k_r;
    px       = desc_r.neg_x ? sx - ox : sx + ox;
    py       = desc_r.neg_y ? sy - oy : sy + oy;
    last     = ({1'b0, k_r} + (CB+1)'(1)) == maj_w;
    step     = busy_r && (!out_valid_r || pop);
    deq      = !q_empty && (!busy_r || (step && last));

    desc_nxt      = desc_r;
    busy_nxt      = busy_r;
    k_nxt         = k_r;
    m_nxt         = m_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (step) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.pixel_x    = CW'(px);
      out_data_nxt.pixel_y    = CW'(py);
      out_data_nxt.last_pixel = last;
      k_nxt                   = k_r + CB'(1);
      m_nxt                   = m_use;
      acc_nxt                 = acc_step;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end

    // load the next line as soon as the current one issues its last pixel
    if (deq) begin
      desc_nxt = head;
      busy_nxt = 1'b1;
      k_nxt    = '0;
      m_nxt    = '0;
      acc_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r     <= desc_nxt;
    k_r        <= k_nxt;
    m_r        <= m_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign empty    = !out_valid_r;
  assign out_data = out_data_r;

endmodule

@@ hw/rtl/line_rasterizer.sv @@
// Top level of the line rasterizer: front classifier, descriptor queue
// and pixel stepper. Depends on lr_pkg, lr_front, lr_queue, lr_stepper.
//
// The line rasterizer takes a pair of endpoints per transaction and returns
// the pixels of the line from the start point toward the end point, one
// pixel per result transaction, with last_pixel set on the final one. The
// start point is drawn, the end point is not, and a line whose endpoints
// coincide returns nothing. Coordinates are taken modulo the tile of
// 2^COORD_BITS pixels on a side. The major axis is x only when |dx| > |dy|;
// the minor coordinate follows floor(k * minor / major) from an error
// accumulator that starts at zero. A line of N major steps yields N pixels,
// up to 2^COORD_BITS - 1, one pixel per cycle while the result register
// is free or being popped. The next line is loaded in the same cycle the
// last pixel of the current one issues, so lines follow without a gap.
// The front accepts one line per cycle, while full is low, into a two-entry
// descriptor queue and drops zero-length lines there; full rises while
// the queue holds two lines waiting for the stepper. The stepper stalls
// while the result register holds a pixel that waits for pop.
module line_rasterizer #(
  parameter int COORD_BITS = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  // input channel
  input  logic            push,
  output logic            full,
  input  lr_pkg::lr_in_t  in_data,
  // result channel
  output logic            empty,
  input  logic            pop,
  output lr_pkg::lr_out_t out_data
);

  logic             enq, deq, q_full, q_empty;
  lr_pkg::lr_desc_t enq_desc, head_desc;

  // Classify the incoming line and drop it if it has no length
  lr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .in_data (in_data),
    .push    (push),
    .q_full  (q_full),
    .enq     (enq),
    .desc    (enq_desc)
  );

  // Hold classified lines until the stepper is free
  lr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .enq      (enq),
    .enq_data (enq_desc),
    .deq      (deq),
    .head     (head_desc),
    .q_full   (q_full),
    .q_empty  (q_empty)
  );

  // Advance along the major axis, one pixel per cycle unless the result waits for pop
  lr_stepper #(
    .COORD_BITS(COORD_BITS)
  ) u_stepper (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head_desc),
    .q_empty  (q_empty),
    .deq      (deq),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

  assign full = q_full;

`ifndef SYNTHESIS
  // A zero-length line must never reach the queue
  a_zero_len_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full &&
     (in_data.start_x[COORD_BITS-1:0] == in_data.end_x[COORD_BITS-1:0]) &&
     (in_data.start_y[COORD_BITS-1:0] == in_data.end_y[COORD_BITS-1:0]))
    |-> !enq)
    else $error("zero-length line enqueued");

  // The stepper only loads a line that is waiting in the queue
  a_deq_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    deq |-> !q_empty)
    else $error("descriptor dequeued from an empty queue");

  // An enqueue is never lost to a full queue
  a_enq_room: assert property (@(posedge clk) disable iff (!rst_n)
    enq |-> !q_full)
    else $error("descriptor enqueued into a full queue");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for line_rasterizer: drives endpoint pairs through
// the push/full queue port and checks every pixel popped from empty/pop.
// Depends on lr_pkg and the line_rasterizer RTL.
`timescale 1ns / 100ps

module tb;

  localparam int COORD_BITS   = 6;
  localparam int CW           = lr_pkg::COORD_W;
  localparam int IN_W         = 4 * lr_pkg::COORD_W;
  localparam int TILE_MASK    = (1 << COORD_BITS) - 1;
  localparam int RANDOM_LINES = 370;
  // lines at the end of the random part sent with both sides streaming
  localparam int QUIET_LINES  = 60;
  // worst case is about 410 lines x 63 pixels, each behind a pop stall burst
  localparam int CYCLE_LIMIT  = 1000000;
  // cycles to keep watching for stray pixels once nothing is expected
  localparam int DRAIN_CYCLES = 200;

  // Scoreboard: predicts the pixels of each accepted line and checks the
  // popped pixels against them in order.
  class pixel_scoreboard;
    lr_pkg::lr_out_t expected_pixels[$];
    int      errors;
    int      lines_accepted;
    int      empty_lines;
    int      pixels_checked;

    task report(input string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    function int outstanding();
      return expected_pixels.size();
    endfunction

    // Walk the major axis one step at a time; the minor offset advances
    // each time the error accumulator reaches the major length.
    function void note_line(lr_pkg::lr_in_t ln);
      logic [CW-1:0]   sx, sy, ex, ey;
      bit              neg_x, neg_y, x_major;
      int              ax, ay, major_len, minor_len, acc, m, k, ox, oy;
      lr_pkg::lr_out_t px;
      sx = CW'(ln.start_x & TILE_MASK);
      sy = CW'(ln.start_y & TILE_MASK);
      ex = CW'(ln.end_x & TILE_MASK);
      ey = CW'(ln.end_y & TILE_MASK);
      neg_x = ex < sx;
      neg_y = ey < sy;
      ax = neg_x ? sx - ex : ex - sx;
      ay = neg_y ? sy - ey : ey - sy;
      x_major   = ax > ay;
      major_len = x_major ? ax : ay;
      minor_len = x_major ? ay : ax;
      acc = 0;
      m   = 0;
      lines_accepted++;
      if (major_len == 0) empty_lines++;
      for (k = 0; k < major_len; k++) begin
        if (acc >= major_len) begin
          m++;
          acc -= major_len;
        end
        acc += minor_len;
        ox = x_major ? k : m;
        oy = x_major ? m : k;
        px.pixel_x    = CW'((neg_x ? sx - ox : sx + ox) & TILE_MASK);
        px.pixel_y    = CW'((neg_y ? sy - oy : sy + oy) & TILE_MASK);
        px.last_pixel = (k + 1 == major_len);
        expected_pixels.push_back(px);
      end
    endfunction

    task check_pixel(input lr_pkg::lr_out_t got);
      lr_pkg::lr_out_t want;
      if (expected_pixels.size() == 0) begin
        report($sformatf("pixel (%0d,%0d) last=%0b with no line pending",
                         got.pixel_x, got.pixel_y, got.last_pixel));
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (got.pixel_x !== want.pixel_x)
          report($sformatf("pixel_x %0d, expected %0d", got.pixel_x, want.pixel_x));
        if (got.pixel_y !== want.pixel_y)
          report($sformatf("pixel_y %0d, expected %0d", got.pixel_y, want.pixel_y));
        if (got.last_pixel !== want.last_pixel)
          report($sformatf("last_pixel %0b, expected %0b at (%0d,%0d)",
                           got.last_pixel, want.last_pixel, want.pixel_x, want.pixel_y));
      end
    endtask
  endclass

  logic            clk;
  logic            rst_n;
  logic            push;
  logic            full;
  lr_pkg::lr_in_t  in_data;
  logic            empty;
  logic            pop;
  lr_pkg::lr_out_t out_data;

  pixel_scoreboard sb;
  bit quiet;            // set for the final stretch: no idling on either side
  int cycles = 0;
  int pop_stall = 0;    // remaining cycles of the current pop stall burst

  line_rasterizer #(.COORD_BITS(COORD_BITS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or never drains.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Result side: a pop transaction completes at an edge where pop was high
  // and empty low; the values sampled here are the pre-edge ones. Then pick
  // the next pop value: streaming, or a stall burst counted down in pop_stall.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_pixel(out_data);
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (pop_stall > 0) begin
      pop_stall <= pop_stall - 1;
      pop <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      pop_stall <= $urandom_range(0, 8);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Present one line and hold it until the edge that accepts it.
  task automatic send_line(input lr_pkg::lr_in_t ln);
    push    <= 1'b1;
    in_data <= ln;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_line(ln);
  endtask

  // Drop push for a burst of cycles, with junk on the data lines.
  task automatic idle_input(input int n);
    push    <= 1'b0;
    in_data <= lr_pkg::lr_in_t'(IN_W'($urandom));
    repeat (n) @(posedge clk);
  endtask

  // Random idling ahead of a line, skipped in the quiet stretch.
  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 3) == 0) idle_input($urandom_range(1, 9));
  endtask

  task automatic send_xy(input int sx, input int sy, input int ex, input int ey);
    lr_pkg::lr_in_t ln;
    ln.start_x = CW'(sx);
    ln.start_y = CW'(sy);
    ln.end_x   = CW'(ex);
    ln.end_y   = CW'(ey);
    maybe_idle();
    send_line(ln);
  endtask

  // A coordinate within a few pixels of c, kept inside the tile.
  function automatic int near_coord(input int c);
    int lo, hi;
    lo = (c < 5) ? 0 : c - 5;
    hi = (c > TILE_MASK - 5) ? TILE_MASK : c + 5;
    return $urandom_range(hi, lo);
  endfunction

  // Arbitrary endpoints; also short lines, axis-aligned and
  // diagonal lines, and the occasional zero-length one.
  function automatic lr_pkg::lr_in_t random_line();
    lr_pkg::lr_in_t ln;
    int             pick, d, ty;
    ln   = lr_pkg::lr_in_t'(IN_W'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      ln.end_x = CW'(near_coord(int'(ln.start_x)));
      ln.end_y = CW'(near_coord(int'(ln.start_y)));
    end else if (pick < 35) begin
      ln.end_y = ln.start_y;
    end else if (pick < 45) begin
      ln.end_x = ln.start_x;
    end else if (pick < 55) begin
      // diagonal: |dx| == |dy|, a tie that goes to y
      d  = int'(ln.end_x) - int'(ln.start_x);
      ty = $urandom_range(0, 1) ? int'(ln.start_y) + d : int'(ln.start_y) - d;
      if (ty >= 0 && ty <= TILE_MASK) ln.end_y = CW'(ty);
    end else if (pick < 60) begin
      ln.end_x = ln.start_x;
      ln.end_y = ln.start_y;
    end
    return ln;
  endfunction

  initial begin
    int             sent;
    lr_pkg::lr_in_t ln;
    sb        = new();
    quiet     = 1'b0;
    rst_n     = 1'b0;
    push      = 1'b0;
    in_data   = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines: zero length, the longest lines along both axes and
    // both diagonals in each direction, single steps, near ties, and
    // coordinates at both ends of the tile.
    send_xy(0, 0, 0, 0);
    send_xy(63, 63, 63, 63);
    send_xy(0, 0, 63, 0);
    send_xy(63, 5, 0, 5);
    send_xy(7, 0, 7, 63);
    send_xy(40, 63, 40, 0);
    send_xy(0, 0, 63, 63);
    send_xy(63, 0, 0, 63);
    send_xy(63, 63, 0, 0);
    send_xy(0, 63, 63, 0);
    send_xy(5, 5, 6, 5);
    send_xy(5, 5, 5, 4);
    send_xy(5, 5, 4, 6);
    send_xy(0, 0, 63, 62);
    send_xy(63, 0, 1, 63);
    send_xy(10, 0, 13, 63);
    send_xy(63, 20, 0, 17);
    send_xy(20, 30, 21, 63);
    send_xy(42, 21, 21, 42);
    send_xy(0, 63, 62, 0);

    // Random lines; zero-length ones produce nothing and do not count.
    sent = 0;
    while (sent < RANDOM_LINES) begin
      if (sent == RANDOM_LINES - QUIET_LINES) quiet = 1'b1;
      // hold off the sender until the block has drained completely
      if (sent == 150 || sent == 300) begin
        push <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
      end
      ln = random_line();
      maybe_idle();
      send_line(ln);
      if (ln.start_x != ln.end_x || ln.start_y != ln.end_y) sent++;
    end
    push <= 1'b0;

    // Drain, then keep popping a while to catch any stray pixel.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d lines (%0d of zero length) and %0d pixels in %0d cycles,",
             sb.lines_accepted, sb.empty_lines, sb.pixels_checked, cycles);
    $display("with random idling on both sides and a streaming stretch at the end.");
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("tb failed");
    end
    $finish;
  end

endmodule
